/* rtl/core/pidc_pkg.sv */
// Shared types, constants and saturation helpers for the PID controller step.
`timescale 1ns / 1ps

package pidc_pkg;

  localparam int DataW = 32;
  localparam int AccW = 48;
  localparam int DtW = 21;
  localparam logic [DtW-1:0] DtDefault = 21'd1049;

  // Configuration register indexes.
  localparam logic [2:0] REG_GAIN_P = 3'd0;
  localparam logic [2:0] REG_GAIN_I = 3'd1;
  localparam logic [2:0] REG_GAIN_D = 3'd2;
  localparam logic [2:0] REG_FILT_COEF = 3'd3;
  localparam logic [2:0] REG_OUT_LIMIT = 3'd4;
  localparam logic [2:0] REG_AW_ENABLE = 3'd5;

  typedef struct packed {
    logic start;
    logic sh20;
  } mul_req_t;

  typedef struct packed {
    logic start;
    logic sh20;
  } div_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -66'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [65:0] x);
    logic signed [47:0] r;
    if (x > 66'sd140737488355327) begin
      r = 48'sh7FFF_FFFF_FFFF;
    end else if (x < -66'sd140737488355328) begin
      r = 48'sh8000_0000_0000;
    end else begin
      r = x[47:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/pidc_mul.sv */
// Shared multiplier: 16-bit digit serial product with floor shift and saturation.
`timescale 1ns / 1ps

module pidc_mul import pidc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  mul_req_t           req,
  input  logic signed [63:0] a,
  input  logic signed [33:0] b,
  output logic               done,
  output logic signed [63:0] res
);

  typedef enum logic [1:0] {M_IDLE, M_ACC, M_FIN1, M_FIN2} mstate_t;

  mstate_t     state;
  logic [63:0] ma;
  logic [33:0] mb;
  logic        neg;
  logic        sh20;
  logic [97:0] acc;
  logic [1:0]  cnt;
  logic [81:0] q;
  logic [49:0] part;
  logic [81:0] shifted;
  logic        rem_nz;

  assign part = ma[63:48] * mb;

  always_comb begin
    if (sh20) begin
      shifted = {4'b0, acc[97:20]};
      rem_nz  = |acc[19:0];
    end else begin
      shifted = acc[97:16];
      rem_nz  = |acc[15:0];
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= M_IDLE;
    end else begin
      unique case (state)
        M_IDLE: begin
          if (req.start) begin
            ma    <= a[63] ? 64'(-a) : 64'(a);
            mb    <= b[33] ? 34'(-b) : 34'(b);
            neg   <= a[63] ^ b[33];
            sh20  <= req.sh20;
            acc   <= '0;
            cnt   <= '0;
            state <= M_ACC;
          end
        end
        M_ACC: begin
          acc <= {acc[81:0], 16'b0} + {48'b0, part};
          ma  <= {ma[47:0], 16'b0};
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            state <= M_FIN1;
          end
        end
        M_FIN1: begin
          // Floor of a negative product: round the magnitude up.
          q     <= shifted + {81'b0, neg & rem_nz};
          state <= M_FIN2;
        end
        M_FIN2: begin
          if (|q[81:63]) begin
            res <= neg ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
          end else begin
            res <= neg ? -$signed(q[63:0]) : $signed(q[63:0]);
          end
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/pidc_div.sv */
// Serial restoring divider: trunc(num * 2^sh / den) with sign and saturation.
`timescale 1ns / 1ps

module pidc_div import pidc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  div_req_t           req,
  input  logic [47:0]        num,
  input  logic               neg_in,
  input  logic [31:0]        den_in,
  output logic               done,
  output logic signed [50:0] res
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

  dstate_t     state;
  logic [67:0] dvd;
  logic [31:0] den;
  logic [32:0] rem;
  logic [49:0] q;
  logic        over;
  logic        neg;
  logic [6:0]  cnt;
  logic [32:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem[31:0], dvd[67]};
  assign fits   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= D_IDLE;
    end else begin
      unique case (state)
        D_IDLE: begin
          if (req.start) begin
            dvd   <= req.sh20 ? {num, 20'b0} : {4'b0, num, 16'b0};
            den   <= den_in;
            neg   <= neg_in;
            rem   <= '0;
            q     <= '0;
            over  <= 1'b0;
            cnt   <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          // A quotient past 50 bits only ever feeds a saturating clamp.
          if (q[49]) begin
            over <= 1'b1;
          end
          if (fits) begin
            rem <= rem_sh - {1'b0, den};
            q   <= {q[48:0], 1'b1};
          end else begin
            rem <= rem_sh;
            q   <= {q[48:0], 1'b0};
          end
          dvd <= {dvd[66:0], 1'b0};
          cnt <= cnt + 7'd1;
          if (cnt == 7'd67) begin
            state <= D_FIN;
          end
        end
        D_FIN: begin
          if (over) begin
            res <= neg ? {1'b1, 50'b0} : {1'b0, {50{1'b1}}};
          end else begin
            res <= neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
          end
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/pid_controller_step.sv */
// PID controller step: sequencer, state registers and configuration.
//
// One input transaction on s_* carries an error sample, a step length and a
// feedforward term; it yields exactly one drive value on m_*. Gains, filter
// coefficient, output limit and anti-windup enable are written on the cfg_*
// port; the user must write them only while the block is idle, and the block
// itself does not enforce it. A sequencer steps one shared digit-serial
// multiplier and one serial divider through the terms. An unfiltered first
// step skips the derivative, the filtered derivative uses only the multiplier,
// the unfiltered one adds a divide, and the anti-windup correction adds its
// gain division; the divider sets the worst case. One item is in work at a
// time: s_tready is high only while the sequencer is idle. The finished
// value sits in an output register, so the next item is accepted while
// m_tvalid waits on m_tready; a stalled receiver only holds the block once
// that register is still full when the next result is ready. Synchronous
// reset restores the default gains, clears the integrator, filter state and
// previous error, and marks the next step as the first one.
`timescale 1ns / 1ps

module pid_controller_step import pidc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // error_value[31:0], time_step[52:32], feedforward[84:53]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // drive[31:0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_P, S_P_W, S_I1, S_I1_W, S_I2, S_I2_W, S_TG, S_TG_W, S_RT, S_RT_W,
    S_DL, S_DL_W, S_DX, S_DX_W, S_DV, S_DV_W, S_SUM, S_KW, S_KW_W, S_A1, S_A1_W,
    S_A2, S_A2_W, S_SUM2, S_OUT
  } state_t;

  state_t state;

  logic signed [31:0] gain_p, gain_i, gain_d, filt_coef;
  logic [30:0]        output_limit;
  logic               aw_en;

  logic signed [31:0] err, ff, p_term, d_term, u_raw, u_sat, fstate, prev_err, drive;
  logic [DtW-1:0]     dt;
  logic signed [47:0] acc;
  logic               first;
  logic signed [63:0] tmp, kaw;

  mul_req_t           mul_req;
  logic signed [63:0] mul_a, mul_res;
  logic signed [33:0] mul_b;
  logic               mul_done;
  div_req_t           div_req;
  logic [47:0]        div_num;
  logic               div_neg;
  logic [31:0]        div_den;
  logic signed [50:0] div_res;
  logic               div_done;

  logic signed [33:0] gap, diff, sat_err, dt_op;
  logic [63:0]        tmp_mag;
  logic [31:0]        gi_mag;
  logic signed [65:0] sum_all;
  logic signed [31:0] u_raw_c, u_sat_c, lim;
  logic signed [47:0] acc_plus;
  logic signed [31:0] f_next;
  logic               filt_on, aw_on;

  pidc_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .res  (mul_res)
  );

  pidc_div u_div (
    .clk    (clk),
    .rst    (rst),
    .req    (div_req),
    .num    (div_num),
    .neg_in (div_neg),
    .den_in (div_den),
    .done   (div_done),
    .res    (div_res)
  );

  assign s_tready = (state == S_IDLE) && !rst;
  assign m_tdata  = drive;

  assign filt_on = !filt_coef[31] && (|filt_coef);
  assign aw_on   = aw_en && !gain_p[31] && (|gain_p) && (|output_limit);

  assign gap     = $signed(tmp[33:0]) - {{2{fstate[31]}}, fstate};
  assign diff    = {{2{err[31]}}, err} - {{2{prev_err[31]}}, prev_err};
  assign sat_err = {{2{u_sat[31]}}, u_sat} - {{2{u_raw[31]}}, u_raw};
  assign dt_op   = {13'b0, dt};
  assign tmp_mag = tmp[63] ? 64'(-tmp) : 64'(tmp);
  assign gi_mag  = gain_i[31] ? 32'(-gain_i) : 32'(gain_i);

  assign sum_all = {{34{p_term[31]}}, p_term} + {{18{acc[47]}}, acc}
                 + {{34{d_term[31]}}, d_term} + {{34{ff[31]}}, ff};
  assign u_raw_c = sat32(sum_all);
  assign lim     = $signed({1'b0, output_limit});

  always_comb begin
    if (lim != 32'sd0 && u_raw_c > lim) begin
      u_sat_c = lim;
    end else if (lim != 32'sd0 && u_raw_c < -lim) begin
      u_sat_c = -lim;
    end else begin
      u_sat_c = u_raw_c;
    end
  end

  assign acc_plus = sat48({{18{acc[47]}}, acc} + {{2{mul_res[63]}}, mul_res});
  assign f_next   = sat32({{34{fstate[31]}}, fstate} + {{2{mul_res[63]}}, mul_res});

  // Operand selection for the shared units.
  always_comb begin
    mul_req = '0;
    mul_a   = '0;
    mul_b   = '0;
    div_req = '0;
    div_num = '0;
    div_neg = 1'b0;
    div_den = '0;
    unique case (state)
      S_P: begin
        mul_req.start = 1'b1;
        mul_a = {{32{gain_p[31]}}, gain_p};
        mul_b = {{2{err[31]}}, err};
      end
      S_I1: begin
        mul_req.start = 1'b1;
        mul_a = {{32{gain_i[31]}}, gain_i};
        mul_b = {{2{err[31]}}, err};
      end
      S_I2, S_DL, S_A2: begin
        mul_req.start = 1'b1;
        mul_req.sh20  = 1'b1;
        mul_a = tmp;
        mul_b = dt_op;
      end
      S_TG: begin
        mul_req.start = 1'b1;
        mul_a = {{32{gain_d[31]}}, gain_d};
        mul_b = {{2{err[31]}}, err};
      end
      S_RT: begin
        mul_req.start = 1'b1;
        mul_a = {{32{filt_coef[31]}}, filt_coef};
        mul_b = gap;
      end
      S_DX: begin
        mul_req.start = 1'b1;
        mul_a = {{32{gain_d[31]}}, gain_d};
        mul_b = diff;
      end
      S_A1: begin
        mul_req.start = 1'b1;
        mul_a = kaw;
        mul_b = sat_err;
      end
      S_DV: begin
        div_req.start = 1'b1;
        div_req.sh20  = 1'b1;
        div_num = tmp_mag[47:0];
        div_neg = tmp[63];
        div_den = {11'b0, dt};
      end
      S_KW: begin
        div_req.start = 1'b1;
        div_num = {16'b0, gi_mag};
        div_neg = gain_i[31];
        div_den = gain_p;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      m_tvalid     <= 1'b0;
      gain_p       <= 32'sh0001_0000;
      gain_i       <= '0;
      gain_d       <= '0;
      filt_coef    <= '0;
      output_limit <= '0;
      aw_en        <= 1'b0;
      acc          <= '0;
      fstate       <= '0;
      prev_err     <= '0;
      first        <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GAIN_P:    gain_p       <= cfg_data;
          REG_GAIN_I:    gain_i       <= cfg_data;
          REG_GAIN_D:    gain_d       <= cfg_data;
          REG_FILT_COEF: filt_coef    <= cfg_data;
          REG_OUT_LIMIT: output_limit <= cfg_data[30:0];
          REG_AW_ENABLE: aw_en        <= cfg_data[0];
          default: ;
        endcase
      end

      // In S_OUT the output register is handled by the state itself.
      if (m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            err   <= s_tdata[31:0];
            dt    <= (s_tdata[52:32] == '0) ? DtDefault : s_tdata[52:32];
            ff    <= s_tdata[84:53];
            state <= S_P;
          end
        end
        S_P:  state <= S_P_W;
        S_P_W: begin
          if (mul_done) begin
            p_term <= sat32({{2{mul_res[63]}}, mul_res});
            state  <= S_I1;
          end
        end
        S_I1: state <= S_I1_W;
        S_I1_W: begin
          if (mul_done) begin
            tmp   <= mul_res;
            state <= S_I2;
          end
        end
        S_I2: state <= S_I2_W;
        S_I2_W: begin
          if (mul_done) begin
            acc <= acc_plus;
            if (filt_on) begin
              state <= S_TG;
            end else if (first) begin
              d_term <= '0;
              state  <= S_SUM;
            end else begin
              state <= S_DX;
            end
          end
        end
        S_TG: state <= S_TG_W;
        S_TG_W: begin
          if (mul_done) begin
            tmp   <= 64'(sat32({{2{mul_res[63]}}, mul_res}));
            state <= S_RT;
          end
        end
        S_RT: state <= S_RT_W;
        S_RT_W: begin
          if (mul_done) begin
            tmp   <= mul_res;
            state <= S_DL;
          end
        end
        S_DL: state <= S_DL_W;
        S_DL_W: begin
          if (mul_done) begin
            fstate <= f_next;
            d_term <= f_next;
            state  <= S_SUM;
          end
        end
        S_DX: state <= S_DX_W;
        S_DX_W: begin
          if (mul_done) begin
            tmp   <= mul_res;
            state <= S_DV;
          end
        end
        S_DV: state <= S_DV_W;
        S_DV_W: begin
          if (div_done) begin
            d_term <= sat32(66'(div_res));
            state  <= S_SUM;
          end
        end
        S_SUM: begin
          u_raw    <= u_raw_c;
          u_sat    <= u_sat_c;
          prev_err <= err;
          first    <= 1'b0;
          state    <= aw_on ? S_KW : S_OUT;
        end
        S_KW: state <= S_KW_W;
        S_KW_W: begin
          if (div_done) begin
            kaw   <= 64'(div_res);
            state <= S_A1;
          end
        end
        S_A1: state <= S_A1_W;
        S_A1_W: begin
          if (mul_done) begin
            tmp   <= mul_res;
            state <= S_A2;
          end
        end
        S_A2: state <= S_A2_W;
        S_A2_W: begin
          if (mul_done) begin
            acc   <= acc_plus;
            state <= S_SUM2;
          end
        end
        S_SUM2: begin
          u_raw <= u_raw_c;
          u_sat <= u_sat_c;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            drive    <= u_sat;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/pidc_checker.sv */
// Port-level checker for the PID controller step, bound to the top level.
`timescale 1ns / 1ps

module pidc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // A stalled result keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or dropped");

  // One item in work at a time: an accepted transaction makes the block busy.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an item is in work");

  // A new result appears only at the end of a step, while the input is closed.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without an item in work");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind pid_controller_step pidc_checker u_pidc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* tb/sv/tb.sv */
// Self-checking testbench for the PID controller step block.
`timescale 1ns / 1ps

module tb;
  import pidc_pkg::*;

  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;
  localparam int DtFrac = 20;
  localparam int FracW = 16;
  localparam int SettleCycles = 260;
  localparam int StallLimit = 20000;
  localparam longint S64Max = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S64Min = 64'sh8000_0000_0000_0000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [87:0] s_tdata;   // error_value[31:0], time_step[52:32], feedforward[84:53]
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // drive[31:0]
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  pid_controller_step u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the configuration and controller state.
  longint kp, ki, kd, filt_coef, out_limit;
  bit     aw_on;
  longint integ, filt_state, last_err;
  bit     first_pending;

  logic [31:0] drive_expect_q[$];
  int   fail_count;
  int   stall_cycles;
  int   recv_hold;
  bit   gaps_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sat_w(input logic signed [127:0] x, input int w);
    logic signed [127:0] hi, lo;
    hi = (128'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return longint'(hi);
    if (x < lo) return longint'(lo);
    return longint'(x);
  endfunction

  // Floor of a*b / 2^sh, saturated to 64 bits.
  function automatic longint mul_floor(input longint a, input longint b, input int sh);
    logic signed [127:0] pa, pb;
    pa = a;
    pb = b;
    return sat_w((pa * pb) >>> sh, 64);
  endfunction

  // Truncated x * 2^sh / den, saturated to 64 bits.
  function automatic longint div_trunc(input longint x, input int sh, input longint den);
    logic signed [127:0] px;
    logic [127:0] num, q;
    px = x;
    num = (px < 0) ? -px : px;
    q = (num << sh) / den;
    if (px < 0) return (q >= (128'd1 << 63)) ? S64Min : -longint'(q);
    return (q > 128'(S64Max)) ? S64Max : longint'(q);
  endfunction

  function automatic longint add_sat(input longint a, input longint b);
    logic signed [127:0] pa, pb;
    pa = a;
    pb = b;
    return sat_w(pa + pb, 64);
  endfunction

  function automatic longint neg_sat(input longint a);
    return (a == S64Min) ? S64Max : -a;
  endfunction

  function automatic longint limit_drive(input longint u);
    if (out_limit > 0) begin
      if (u > out_limit) return out_limit;
      if (u < -out_limit) return -out_limit;
    end
    return u;
  endfunction

  function automatic longint sum_terms(input longint p, input longint d, input longint ff);
    return sat_w(add_sat(add_sat(add_sat(p, integ), d), ff), DataW);
  endfunction

  function automatic void apply_config(input logic [2:0] idx, input logic [31:0] data);
    case (idx)
      REG_GAIN_P: kp = longint'(signed'(data));
      REG_GAIN_I: ki = longint'(signed'(data));
      REG_GAIN_D: kd = longint'(signed'(data));
      REG_FILT_COEF: filt_coef = longint'(signed'(data));
      REG_OUT_LIMIT: out_limit = longint'(data[30:0]);
      REG_AW_ENABLE: aw_on = data[0];
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] predict_drive(input logic [31:0] err_bits,
                                                 input logic [20:0] dt_bits,
                                                 input logic [31:0] ff_bits);
    longint err, dt, ff, p, d, inc, u_raw, u_sat, target, gap, rate, kaw, corr;
    err = longint'(signed'(err_bits));
    ff = longint'(signed'(ff_bits));
    dt = (dt_bits == 0) ? longint'(DtDefault) : longint'(dt_bits);
    d = 0;
    p = sat_w(mul_floor(kp, err, FracW), DataW);
    inc = mul_floor(mul_floor(ki, err, FracW), dt, DtFrac);
    integ = sat_w(add_sat(integ, inc), AccW);
    if (filt_coef > 0) begin
      target = sat_w(mul_floor(kd, err, FracW), DataW);
      gap = add_sat(target, neg_sat(filt_state));
      rate = mul_floor(filt_coef, gap, FracW);
      filt_state = sat_w(add_sat(filt_state, mul_floor(rate, dt, DtFrac)), DataW);
      d = filt_state;
    end else if (!first_pending) begin
      d = sat_w(div_trunc(mul_floor(kd, err - last_err, FracW), DtFrac, dt), DataW);
    end
    last_err = err;
    first_pending = 1'b0;
    u_raw = sum_terms(p, d, ff);
    u_sat = limit_drive(u_raw);
    if (aw_on && kp > 0 && out_limit > 0) begin
      kaw = div_trunc(ki, FracW, kp);
      corr = mul_floor(mul_floor(kaw, add_sat(u_sat, neg_sat(u_raw)), FracW), dt, DtFrac);
      integ = sat_w(add_sat(integ, corr), AccW);
      u_raw = sum_terms(p, d, ff);
      u_sat = limit_drive(u_raw);
    end
    return u_sat[31:0];
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (drive_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected drive %h", m_tdata));
      end else begin
        if (m_tdata !== drive_expect_q[0])
          report_mismatch($sformatf("drive %h, expected %h", m_tdata, drive_expect_q[0]));
        void'(drive_expect_q.pop_front());
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("watchdog expired with %0d results outstanding", drive_expect_q.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  initial begin
    int k;
    m_tready = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (recv_hold > 0) begin
        m_tready <= 1'b0;
        repeat (recv_hold) @(posedge clk);
        recv_hold = 0;
      end
      k = gaps_on ? $urandom_range(0, 13) : 0;
      if (k > 0) begin
        m_tready <= 1'b0;
        repeat (k) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic send_item(input logic [31:0] err, input logic [20:0] dt,
                           input logic [31:0] ff);
    int k;
    k = gaps_on ? $urandom_range(0, 13) : 0;
    if (k > 0) begin
      s_tvalid <= 1'b0;
      repeat (k) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, ff, dt, err};
    do @(posedge clk); while (!s_tready);
    drive_expect_q.push_back(predict_drive(err, dt, ff));
  endtask

  // Stop offering and wait until every result is back and the block is idle.
  task automatic drain;
    s_tvalid <= 1'b0;
    while (drive_expect_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_config(idx, data);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
      default: return 32'($signed($urandom_range(0, 32'h3FFFFF)) - 32'sh1FFFFF);
    endcase
  endfunction

  function automatic logic [20:0] rand_step();
    case ($urandom_range(0, 5))
      0: return 21'd0;
      1: return 21'($urandom());
      2: return 21'($urandom_range(1, 64));
      default: return 21'($urandom_range(1, 4096));
    endcase
  endfunction

  task automatic send_random(input int n);
    repeat (n) send_item(rand_value(), rand_step(), rand_value());
  endtask

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($urandom_range(0, 32'h3_0000));
      2: return 32'(-$signed($urandom_range(0, 32'h3_0000)));
      default: return 32'($urandom_range(32'h100, 32'h8_0000));
    endcase
  endfunction

  task automatic test_directed;
    // First step after reset: no derivative term yet.
    write_reg(REG_GAIN_D, 32'h0002_0000);
    send_item(32'h0001_0000, 21'd0, 32'h0);
    send_item(32'h8000_0000, 21'd1, 32'h7FFF_FFFF);
    send_item(32'h7FFF_FFFF, 21'h1F_FFFF, 32'h8000_0000);
    send_item(32'h0, 21'h10_0000, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 21'd0, 32'h0);
    drain();
    write_reg(REG_GAIN_I, 32'h0004_0000);
    write_reg(REG_OUT_LIMIT, 32'h8002_0000);
    write_reg(REG_AW_ENABLE, 32'hFFFF_FFFE);
    send_item(32'h0003_0000, 21'd1049, 32'h0);
    send_item(32'h7FFF_FFFF, 21'h1F_FFFF, 32'h7FFF_FFFF);
    drain();
    write_reg(REG_AW_ENABLE, 32'h1);
    write_reg(REG_SPARE_6, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_7, 32'h1234_5678);
    send_item(32'h0005_0000, 21'd0, 32'h0001_0000);
    send_item(32'h8000_0000, 21'h1F_FFFF, 32'h8000_0000);
    send_item(32'hFFFE_0000, 21'd2000, 32'h0);
    drain();
    // Anti-windup must stay off with a non-positive proportional gain.
    write_reg(REG_GAIN_P, 32'h8000_0000);
    send_item(32'h0001_0000, 21'd500, 32'h0);
    send_item(32'hFFFF_0000, 21'd0, 32'h7FFF_FFFF);
    drain();
    write_reg(REG_GAIN_P, 32'h7FFF_FFFF);
    write_reg(REG_FILT_COEF, 32'h0064_0000);
    send_item(32'h0002_0000, 21'd1049, 32'h0);
    send_item(32'h7FFF_FFFF, 21'h1F_FFFF, 32'h0);
    send_item(32'h8000_0000, 21'd1, 32'h0);
    drain();
    write_reg(REG_FILT_COEF, 32'h8000_0000);
    write_reg(REG_OUT_LIMIT, 32'h7FFF_FFFF);
    send_item(32'h0010_0000, 21'd100, 32'h0);
    send_item(32'h0, 21'd0, 32'h0);
    drain();
  endtask

  task automatic test_random_settings(input int phases, input int per_phase);
    repeat (phases) begin
      write_reg(REG_GAIN_P, rand_gain());
      write_reg(REG_GAIN_I, rand_gain());
      write_reg(REG_GAIN_D, rand_gain());
      write_reg(REG_FILT_COEF, $urandom_range(0, 1) ? rand_gain() : 32'h0);
      write_reg(REG_OUT_LIMIT, $urandom_range(0, 3) == 0 ? 32'h0 :
                ($urandom_range(0, 1) ? $urandom() : 32'($urandom_range(1, 32'h40_0000))));
      write_reg(REG_AW_ENABLE, $urandom());
      gaps_on = ($urandom_range(0, 3) != 0);
      send_random(per_phase);
      drain();
    end
  endtask

  task automatic test_backpressure;
    gaps_on = 1'b0;
    recv_hold = 400;
    send_random(6);
    drain();
    gaps_on = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fail_count = 0;
    recv_hold = 0;
    gaps_on = 1'b1;
    kp = 64'sd65536;
    ki = 0;
    kd = 0;
    filt_coef = 0;
    out_limit = 0;
    aw_on = 1'b0;
    integ = 0;
    filt_state = 0;
    last_err = 0;
    first_pending = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_settings(12, 140);
    test_backpressure();
    drain();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
